### hdl/dtcf_pkg.sv
// ----------------------------------------------------------------------------
// dtcf_pkg
// Shared widths, register indexes and types for the binary64 to reduced
// float converter.
// ----------------------------------------------------------------------------
package dtcf_pkg;

  localparam int unsigned F64_W      = 64;
  localparam int unsigned F64_FBITS  = 52;
  localparam int unsigned F64_SBITS  = 53;
  localparam int unsigned F64_EBITS  = 11;
  localparam int unsigned F64_BIAS   = 1023;
  localparam int unsigned RND_W      = 51;
  localparam int unsigned RES_W      = 63;

  localparam int unsigned PREC_W     = 6;
  localparam int unsigned EMAX_W     = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_PRECISION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOCHASTIC = 2'd2;

  localparam logic [PREC_W-1:0] PREC_RESET = 6'd24;
  localparam logic [EMAX_W-1:0] EMAX_RESET = 10'd127;
  localparam logic [PREC_W-1:0] PREC_MIN   = 6'd2;
  localparam logic [PREC_W-1:0] PREC_MAX   = 6'd52;

  typedef struct packed {
    logic [PREC_W-1:0] precision;
    logic [EMAX_W-1:0] max_exponent;
    logic              stochastic;
  } dtcf_cfg_t;

endpackage

### hdl/dtcf_if.sv
// ----------------------------------------------------------------------------
// dtcf_if
// Valid/ready channels of the converter: input items, results, register
// writes.
// ----------------------------------------------------------------------------
interface dtcf_in_if
  import dtcf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [F64_W-1:0]   value_bits;
  logic [RND_W-1:0]   random_bits;

  modport source (output valid, output value_bits, output random_bits, input ready);
  modport sink   (input valid, input value_bits, input random_bits, output ready);
endinterface

interface dtcf_out_if
  import dtcf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [RES_W-1:0]   result_bits;

  modport source (output valid, output result_bits, input ready);
  modport sink   (input valid, input result_bits, output ready);
endinterface

interface dtcf_cfg_if
  import dtcf_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/double_to_custom_float_round_core.sv
// ----------------------------------------------------------------------------
// double_to_custom_float_round_core
// Converts binary64 bit patterns to a float of configurable precision and
// exponent bias, rounding to nearest (ties away) or stochastically. One item
// is taken per cycle as long as results are taken; each input is held in
// the input register, then goes through the conversion logic into the
// result register, from which the result is offered. Registers are
// written through the configuration channel, which is always ready; write
// them only while no item is in flight.
// ----------------------------------------------------------------------------
module double_to_custom_float_round_core
  import dtcf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  dtcf_cfg_if.sink         cfg_i,
  dtcf_in_if.sink          src_i,
  dtcf_out_if.source       res_o
);

  logic [PREC_W-1:0] prec_q;
  logic [EMAX_W-1:0] emax_q;
  logic              stoch_q;
  dtcf_cfg_t         cfg;

  logic              in_valid_q;
  logic [F64_W-1:0]  value_q;
  logic [RND_W-1:0]  rnd_q;
  logic              out_valid_q;
  logic [RES_W-1:0]  result_q;
  logic [RES_W-1:0]  result_d;
  logic              out_adv;
  logic              in_adv;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q  <= PREC_RESET;
      emax_q  <= EMAX_RESET;
      stoch_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_PRECISION:  prec_q  <= cfg_i.data[PREC_W-1:0];
        CFG_MAX_EXP:    emax_q  <= cfg_i.data[EMAX_W-1:0];
        CFG_STOCHASTIC: stoch_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign cfg = '{precision: prec_q, max_exponent: emax_q, stochastic: stoch_q};

  // result register frees when empty or taken; input stage moves behind it
  assign out_adv     = !out_valid_q || res_o.ready;
  assign in_adv      = in_valid_q && out_adv;
  assign src_i.ready = !in_valid_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (src_i.ready) in_valid_q <= src_i.valid;
      if (out_adv) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_i.valid && src_i.ready) begin
      value_q <= src_i.value_bits;
      rnd_q   <= src_i.random_bits;
    end
    if (in_adv) result_q <= result_d;
  end

  dtcf_convert u_convert (
    .cfg_i    (cfg),
    .value_i  (value_q),
    .random_i (rnd_q),
    .result_o (result_d)
  );

  assign res_o.valid       = out_valid_q;
  assign res_o.result_bits = result_q;

endmodule

### hdl/dtcf_convert.sv
// ----------------------------------------------------------------------------
// dtcf_convert
// Combinational conversion of one binary64 pattern to the reduced format:
// special values, overflow, subnormal shift and the rounding increment.
// ----------------------------------------------------------------------------
module dtcf_convert
  import dtcf_pkg::*;
(
  input  dtcf_cfg_t        cfg_i,
  input  logic [F64_W-1:0] value_i,
  input  logic [RND_W-1:0] random_i,
  output logic [RES_W-1:0] result_o
);

  logic [PREC_W-1:0]        prec;
  logic [PREC_W-1:0]        t;
  logic [PREC_W-1:0]        n;
  logic [EMAX_W:0]          emax_p1;
  logic [3:0]               w;
  logic [F64_EBITS-1:0]     dexp;
  logic [F64_FBITS-1:0]     frac;
  logic                     sub_in;
  logic [F64_SBITS-1:0]     sig;
  logic signed [12:0]       e;
  logic signed [12:0]       big;
  logic signed [12:0]       s;
  logic [5:0]               s_m1;
  logic [F64_SBITS-1:0]     sig_sh;
  logic [F64_SBITS-1:0]     sub_m;
  logic [RES_W-1:0]         sign_v;
  logic [RES_W-1:0]         expones;
  logic [RES_W-1:0]         nan_v;
  logic [F64_FBITS-1:0]     tmask;
  logic                     inc;
  logic [RES_W-1:0]         body;

  // clamp precision to the supported range
  always_comb begin
    if (cfg_i.precision < PREC_MIN) begin
      prec = PREC_MIN;
    end else if (cfg_i.precision > PREC_MAX) begin
      prec = PREC_MAX;
    end else begin
      prec = cfg_i.precision;
    end
  end

  assign t       = prec - 6'd1;
  assign n       = 6'(F64_FBITS) - t;
  assign emax_p1 = {1'b0, cfg_i.max_exponent} + 11'd1;

  // exponent field width: bit length of emax + 1
  always_comb begin
    w = 4'd0;
    for (int i = 0; i <= EMAX_W; i++) begin
      if (emax_p1[i]) w = 4'(i + 1);
    end
  end

  assign dexp   = value_i[F64_W-2 -: F64_EBITS];
  assign frac   = value_i[F64_FBITS-1:0];
  assign sub_in = (dexp == '0);
  assign sig    = sub_in ? {1'b0, frac} : {1'b1, frac};

  assign e   = (sub_in ? 13'sd1 : $signed({2'b00, dexp})) - 13'sd1023
             + $signed({3'b000, cfg_i.max_exponent});
  assign big = $signed(13'((13'd1 << w) - 13'd1));

  assign sign_v  = value_i[F64_W-1] ? (63'd1 << (7'(w) + 7'(t))) : '0;
  assign expones = ((63'd1 << w) - 63'd1) << t;
  assign nan_v   = expones | (63'd1 << (t - 6'd1));

  // subnormal result: shift by 53-t-e, round on the last dropped bit
  assign s      = 13'sd53 - $signed({7'b0, t}) - e;
  assign s_m1   = 6'(s[5:0] - 6'd1);
  assign sig_sh = sig >> s_m1;
  always_comb begin
    if (s <= 13'sd53) begin
      sub_m = (sig_sh >> 1) + {52'b0, sig_sh[0]};
    end else begin
      sub_m = '0;
    end
  end

  // normal result: exponent and truncated fraction, carry runs into exponent
  assign tmask = (52'd1 << n) - 52'd1;
  always_comb begin
    if (cfg_i.stochastic) begin
      inc = ({1'b0, random_i} & tmask) < (frac & tmask);
    end else begin
      inc = frac[n - 6'd1];
    end
  end

  assign body = ({52'b0, e[10:0]} << t) + 63'(frac >> n) + {62'b0, inc};

  always_comb begin
    priority if (value_i[F64_W-2:0] == '0) begin
      result_o = sign_v;
    end else if (dexp == '1) begin
      result_o = (frac == '0) ? (sign_v | expones) : nan_v;
    end else if (e >= big) begin
      result_o = sign_v | expones;
    end else if (e <= 13'sd0 || sub_in) begin
      result_o = sign_v | {10'b0, sub_m};
    end else begin
      result_o = sign_v | body;
    end
  end

endmodule
